// ===== hdl/font_dict_select_lookup_top_assert.svh =====
// assertion macros for the font dictionary selection lookup
`ifndef FONT_DICT_SELECT_LOOKUP_TOP_ASSERT_SVH
`define FONT_DICT_SELECT_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FDSL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fdsl same-cycle check failed");

// next-cycle implication, checked outside reset
`define FDSL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdsl next-cycle check failed");

`endif

// ===== hdl/fdsl_pkg.sv =====
// shared types and codes for the font dictionary selection lookup
package fdsl_pkg;

   // command codes
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;
   // spare command, accepted and ignored
   localparam logic [1:0] ACT_NOP    = 2'd3;

   // result status codes
   localparam logic [1:0] STS_FOUND   = 2'd0;
   localparam logic [1:0] STS_RANGE   = 2'd1;
   localparam logic [1:0] STS_INVALID = 2'd2;

   // table formats
   localparam logic [2:0] FMT_BYTES  = 3'd0;
   localparam logic [2:0] FMT_SHORT  = 3'd3;
   localparam logic [2:0] FMT_LONG   = 3'd4;

   // control register indexes
   localparam logic [2:0] CSR_FORMAT     = 3'd0;
   localparam logic [2:0] CSR_GLYPH_CNT  = 3'd1;
   localparam logic [2:0] CSR_DICT_CNT   = 3'd2;
   localparam logic [2:0] CSR_RANGE_CNT  = 3'd3;
   localparam logic [2:0] CSR_END_GLYPH  = 3'd4;

   // one stored table entry
   typedef struct packed {
      logic [31:0] start_glyph;
      logic [15:0] dictionary;
   } fdsl_entry_type;

   // lookup sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIRECT,
      ST_FINISH
   } fdsl_state_type;

endpackage

// ===== hdl/font_dict_select_lookup_top.sv =====
// font dictionary selection table: loader, checker and lookup sequencer
// clear and append are done at accept and give no result; busy stays low
// lookup of an invalid table or an out-of-range glyph: result registered at accept, no memory read
// format 0 lookup: one entry memory read, then the result is registered in ST_DIRECT
// range lookup: binary search in ST_SEARCH, then ST_FINISH; one at a time; no output stall
// sync reset resets state, strobe, fill count, fault and control registers, not entry memory
`include "font_dict_select_lookup_top_assert.svh"

module font_dict_select_lookup_top #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_entry_first_glyph,
   input  logic [15:0] req_entry_dictionary,
   input  logic [31:0] req_glyph_index,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_dictionary_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fdsl_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

   // control registers
   logic [2:0]  format_ff;
   logic [31:0] glyph_cnt_ff;
   logic [15:0] dict_cnt_ff;
   logic [10:0] range_cnt_ff;
   logic [31:0] end_glyph_ff;

   // table state
   logic [CW-1:0] loaded_ff, loaded_in;
   logic [31:0]   prev_ff, prev_in;
   logic          fault_ff, fault_in;

   // sequencer
   fdsl_state_type state_ff, state_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [31:0]   glyph_ff, glyph_in;
   logic [15:0]   cand_ff, cand_in;
   logic          hit_ff, hit_in;

   // result registers
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_dict_ff, rsp_dict_in;

   // entry memory ports
   fdsl_entry_type store_mem [MAX_ENTRIES];
   fdsl_entry_type rd_data_ff;
   fdsl_entry_type wr_data;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;

   // search step helpers
   logic          accept;
   logic          table_ok;
   logic          append_bad;
   logic          below;
   logic [CW-1:0] lo_nx, hi_nx, mid_nx;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_dictionary_index = rsp_dict_ff;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_BYTES;
         glyph_cnt_ff <= '0;
         dict_cnt_ff  <= 16'd1;
         range_cnt_ff <= '0;
         end_glyph_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FORMAT:    format_ff    <= csr_wdata[2:0];
            CSR_GLYPH_CNT: glyph_cnt_ff <= csr_wdata;
            CSR_DICT_CNT:  dict_cnt_ff  <= csr_wdata[15:0];
            CSR_RANGE_CNT: range_cnt_ff <= csr_wdata[10:0];
            CSR_END_GLYPH: end_glyph_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table validity as seen by a lookup
   always_comb begin
      table_ok = 1'b0;
      if (dict_cnt_ff != '0 && !fault_ff) begin
         if (format_ff == FMT_BYTES) begin
            table_ok = (32'(loaded_ff) == glyph_cnt_ff);
         end else if (format_ff == FMT_SHORT || format_ff == FMT_LONG) begin
            table_ok = (range_cnt_ff != '0) && (32'(range_cnt_ff) == 32'(loaded_ff))
                    && (end_glyph_ff == glyph_cnt_ff)
                    && !(format_ff == FMT_SHORT && (|end_glyph_ff[31:16]));
         end
      end
   end

   // checks on an appended entry
   always_comb begin
      append_bad = (req_entry_dictionary >= dict_cnt_ff);
      if ((format_ff == FMT_BYTES || format_ff == FMT_SHORT) && (|req_entry_dictionary[15:8]))
         append_bad = 1'b1;
      if (format_ff == FMT_SHORT && (|req_entry_first_glyph[31:16]))
         append_bad = 1'b1;
      if (format_ff == FMT_SHORT || format_ff == FMT_LONG) begin
         if (loaded_ff == '0) begin
            if (req_entry_first_glyph != '0)
               append_bad = 1'b1;
         end else if (req_entry_first_glyph <= prev_ff) begin
            append_bad = 1'b1;
         end
      end
   end

   // one binary search step on the entry just read
   always_comb begin
      below = (glyph_ff < rd_data_ff.start_glyph);
      lo_nx = below ? lo_ff : (mid_ff + CW'(1));
      hi_nx = below ? mid_ff : hi_ff;
      mid_nx = lo_nx + ((hi_nx - lo_nx) >> 1);
   end

   // sequencer next state, memory control and results
   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      prev_in       = prev_ff;
      fault_in      = fault_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      glyph_in      = glyph_ff;
      cand_in       = cand_ff;
      hit_in        = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_dict_in   = rsp_dict_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = loaded_ff[AW-1:0];
      wr_data.start_glyph = (format_ff == FMT_BYTES) ? 32'd0 : req_entry_first_glyph;
      wr_data.dictionary  = req_entry_dictionary;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_CLEAR: begin
                     loaded_in = '0;
                     prev_in   = '0;
                     fault_in  = 1'b0;
                  end
                  ACT_APPEND: begin
                     if (loaded_ff >= MAX_CNT) begin
                        fault_in = 1'b1;
                     end else begin
                        if (append_bad)
                           fault_in = 1'b1;
                        wr_en     = 1'b1;
                        loaded_in = loaded_ff + CW'(1);
                        prev_in   = req_entry_first_glyph;
                     end
                  end
                  ACT_LOOKUP: begin
                     glyph_in = req_glyph_index;
                     if (!table_ok) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_INVALID;
                        rsp_dict_in   = '0;
                     end else if (req_glyph_index >= glyph_cnt_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_RANGE;
                        rsp_dict_in   = '0;
                     end else if (format_ff == FMT_BYTES) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_glyph_index[AW-1:0];
                        state_in = ST_DIRECT;
                     end else begin
                        lo_in    = '0;
                        hi_in    = loaded_ff;
                        mid_in   = loaded_ff >> 1;
                        hit_in   = 1'b0;
                        rd_en    = 1'b1;
                        rd_addr  = mid_in[AW-1:0];
                        state_in = ST_SEARCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            lo_in = lo_nx;
            hi_in = hi_nx;
            if (!below) begin
               cand_in = rd_data_ff.dictionary;
               hit_in  = 1'b1;
            end
            if (lo_nx < hi_nx) begin
               mid_in  = mid_nx;
               rd_en   = 1'b1;
               rd_addr = mid_nx[AW-1:0];
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIRECT: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (rd_data_ff.dictionary >= dict_cnt_ff) begin
               rsp_status_in = STS_INVALID;
               rsp_dict_in   = '0;
            end else begin
               rsp_status_in = STS_FOUND;
               rsp_dict_in   = rd_data_ff.dictionary;
            end
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (!hit_ff || cand_ff >= dict_cnt_ff) begin
               rsp_status_in = STS_INVALID;
               rsp_dict_in   = '0;
            end else begin
               rsp_status_in = STS_FOUND;
               rsp_dict_in   = cand_ff;
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         loaded_ff     <= '0;
         prev_ff       <= '0;
         fault_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         prev_ff       <= prev_in;
         fault_ff      <= fault_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // search and result payload
   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      glyph_ff      <= glyph_in;
      cand_ff       <= cand_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dict_ff   <= rsp_dict_in;
   end

   // entry memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en)
         store_mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= store_mem[rd_addr];
   end

   // checks
   `FDSL_ASSERT_NOW(a_fill_bound, 1'b1, loaded_ff <= MAX_CNT)
   `FDSL_ASSERT_NOW(a_search_window, state_ff == ST_SEARCH, lo_ff < hi_ff && mid_ff < hi_ff)
   `FDSL_ASSERT_NOW(a_found_dict, rsp_strobe_ff && rsp_status_ff == STS_FOUND,
      rsp_dict_ff < dict_cnt_ff)
   `FDSL_ASSERT_NOW(a_fail_zero, rsp_strobe_ff && rsp_status_ff != STS_FOUND, rsp_dict_ff == '0)
   `FDSL_ASSERT_NEXT(a_lookup_progress, accept && req_action == ACT_LOOKUP,
      busy || rsp_strobe_ff)

endmodule

// ===== bench/tb_font_dict_select_lookup_top.sv =====
// self-checking testbench for the font dictionary selection lookup
`timescale 1ns / 100ps

module tb_font_dict_select_lookup_top;
   import fdsl_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int RANDOM_ITEMS = 700;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT = 600000;
   localparam longint unsigned FULL_SPAN = 4000000;
   // index with no register behind it, writes must be ignored
   localparam logic [2:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] dictionary;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_action = ACT_CLEAR;
   logic [31:0] req_entry_first_glyph = '0;
   logic [15:0] req_entry_dictionary = '0;
   logic [31:0] req_glyph_index = '0;
   logic        csr_valid = 1'b0;
   logic [2:0]  csr_index = CSR_FORMAT;
   logic [31:0] csr_wdata = '0;
   wire         busy;
   wire         rsp_strobe;
   wire  [1:0]  rsp_status;
   wire  [15:0] rsp_dictionary_index;
   wire         csr_ready;

   // predicted configuration and table state
   bit [2:0]  cfg_format = FMT_BYTES;
   bit [31:0] cfg_glyphs = '0;
   bit [15:0] cfg_dicts = 16'd1;
   bit [10:0] cfg_ranges = '0;
   bit [31:0] cfg_sentinel = '0;
   bit [31:0] tbl_first [STORE_DEPTH];
   bit [15:0] tbl_dict [STORE_DEPTH];
   int        tbl_loaded = 0;
   bit [31:0] tbl_prev_first = '0;
   bit        tbl_fault = 1'b0;

   answer_type pending_answers [$];
   int        burst_left = 0;
   int        items_sent = 0;
   int        n_lookups = 0;
   int        n_appends = 0;
   int        n_clears = 0;
   int        n_ignored = 0;
   int        n_setups = 0;
   int        answers_checked = 0;
   int        mismatch_count = 0;
   int        cycle_count = 0;

   font_dict_select_lookup_top #(.MAX_ENTRIES(STORE_DEPTH)) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_action            (req_action),
      .req_entry_first_glyph (req_entry_first_glyph),
      .req_entry_dictionary  (req_entry_dictionary),
      .req_glyph_index       (req_glyph_index),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_dictionary_index  (rsp_dictionary_index),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
                  pending_answers.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // table append with on-arrival checks
   function automatic void table_append(bit [31:0] first, bit [15:0] dict);
      bit bad;
      if (tbl_loaded == STORE_DEPTH) begin
         tbl_fault = 1'b1;
         return;
      end
      bad = (dict >= cfg_dicts);
      if ((cfg_format == FMT_BYTES || cfg_format == FMT_SHORT) && dict > 16'h00FF)
         bad = 1'b1;
      if (cfg_format == FMT_SHORT && first > 32'h0000_FFFF)
         bad = 1'b1;
      if (cfg_format == FMT_SHORT || cfg_format == FMT_LONG) begin
         if (tbl_loaded == 0)
            bad = bad | (first != 32'd0);
         else
            bad = bad | (first <= tbl_prev_first);
      end
      tbl_first[tbl_loaded] = (cfg_format == FMT_BYTES) ? 32'd0 : first;
      tbl_dict[tbl_loaded] = dict;
      tbl_loaded++;
      tbl_prev_first = first;
      tbl_fault = tbl_fault | bad;
   endfunction

   // dictionary selected for a glyph, with table validity
   function automatic answer_type dictionary_for_glyph(bit [31:0] glyph);
      answer_type ans;
      bit      usable;
      int      sel;
      int      lo;
      int      hi;
      int      mid;
      ans = '0;
      ans.status = STS_FOUND;
      usable = (cfg_dicts != 16'd0) && !tbl_fault;
      case (cfg_format)
         FMT_BYTES: usable = usable && (tbl_loaded == cfg_glyphs);
         FMT_SHORT, FMT_LONG: begin
            usable = usable && (cfg_ranges != 11'd0) && (cfg_ranges == tbl_loaded)
                     && (cfg_sentinel == cfg_glyphs);
            if (cfg_format == FMT_SHORT && cfg_sentinel > 32'h0000_FFFF)
               usable = 1'b0;
         end
         default: usable = 1'b0;
      endcase
      if (!usable) begin
         ans.status = STS_INVALID;
         return ans;
      end
      if (glyph >= cfg_glyphs) begin
         ans.status = STS_RANGE;
         return ans;
      end
      if (cfg_format == FMT_BYTES) begin
         sel = int'(glyph);
      end else begin
         // binary search for the last range whose first glyph is not above the index
         lo = 0;
         hi = tbl_loaded;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (glyph < tbl_first[mid])
               hi = mid;
            else
               lo = mid + 1;
         end
         if (lo == 0 || tbl_first[lo - 1] > glyph) begin
            ans.status = STS_INVALID;
            return ans;
         end
         sel = lo - 1;
      end
      if (tbl_dict[sel] >= cfg_dicts)
         ans.status = STS_INVALID;
      else
         ans.dictionary = tbl_dict[sel];
      return ans;
   endfunction

   task automatic report_mismatch(string what, answer_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s: expected status %0d dict %0d, got status %0d dict %0d",
                  cycle_count, what, want.status, want.dictionary, rsp_status,
                  rsp_dictionary_index);
   endtask

   // result checker, one transfer per strobe
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            want = '0;
            report_mismatch("result with no lookup pending", want);
         end else begin
            want = pending_answers.pop_front();
            answers_checked++;
            if (rsp_status !== want.status || rsp_dictionary_index !== want.dictionary)
               report_mismatch("lookup answer", want);
         end
      end
   end

   // one command transfer, paced in bursts with random gaps
   task automatic send_item(bit [1:0] act, bit [31:0] first, bit [15:0] dict,
                            bit [31:0] glyph);
      int gap;
      if (burst_left == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start <= 1'b1;
      req_action <= act;
      req_entry_first_glyph <= first;
      req_entry_dictionary <= dict;
      req_glyph_index <= glyph;
      do @(posedge clock); while (busy);
      // accepted at this edge
      case (act)
         ACT_CLEAR: begin
            tbl_loaded = 0;
            tbl_prev_first = '0;
            tbl_fault = 1'b0;
            n_clears++;
         end
         ACT_APPEND: begin
            table_append(first, dict);
            n_appends++;
         end
         ACT_LOOKUP: begin
            pending_answers.push_back(dictionary_for_glyph(glyph));
            n_lookups++;
         end
         default: n_ignored++;
      endcase
      if (act != ACT_NOP)
         items_sent++;
   endtask

   task automatic lookup(bit [31:0] glyph);
      send_item(ACT_LOOKUP, $urandom(), 16'($urandom()), glyph);
   endtask

   task automatic append(bit [31:0] first, bit [15:0] dict);
      send_item(ACT_APPEND, first, dict, $urandom());
   endtask

   task automatic clear_table();
      send_item(ACT_CLEAR, $urandom(), 16'($urandom()), $urandom());
   endtask

   // hold off until every answer is in and the block has settled
   task automatic wait_quiet();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, leaves valid high for a following write
   task automatic write_csr(logic [2:0] idx, bit [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FORMAT:    cfg_format = data[2:0];
         CSR_GLYPH_CNT: cfg_glyphs = data;
         CSR_DICT_CNT:  cfg_dicts = data[15:0];
         CSR_RANGE_CNT: cfg_ranges = data[10:0];
         CSR_END_GLYPH: cfg_sentinel = data;
         default: ;
      endcase
   endtask

   // full register setup; unused upper data bits carry noise
   task automatic set_config(bit [2:0] fmt, bit [31:0] glyphs, bit [15:0] dicts,
                             bit [10:0] ranges, bit [31:0] sentinel);
      wait_quiet();
      write_csr(CSR_FORMAT, ($urandom() & ~32'h7) | 32'(fmt));
      write_csr(CSR_GLYPH_CNT, glyphs);
      write_csr(CSR_DICT_CNT, {16'($urandom()), dicts});
      write_csr(CSR_RANGE_CNT, ($urandom() & ~32'h7FF) | 32'(ranges));
      write_csr(CSR_END_GLYPH, sentinel);
      csr_valid <= 1'b0;
      n_setups++;
   endtask

   // reset values: empty byte table over zero glyphs, every glyph out of range
   task automatic test_reset_state();
      lookup(32'd0);
      lookup(32'hFFFF_FFFF);
      send_item(ACT_NOP, $urandom(), 16'($urandom()), $urandom());
   endtask

   // per-glyph bytes: direct reads, overfull table, wide dictionary
   task automatic test_byte_table();
      set_config(FMT_BYTES, 32'd4, 16'd256, 11'd0, 32'd0);
      clear_table();
      append($urandom(), 16'd0);
      append($urandom(), 16'd255);
      append($urandom(), 16'd17);
      append($urandom(), 16'd128);
      for (int g = 0; g <= 4; g++)
         lookup(32'(g));
      // one entry too many
      append($urandom(), 16'd1);
      lookup(32'd1);
      set_config(FMT_BYTES, 32'd1, 16'hFFFF, 11'd0, 32'd0);
      clear_table();
      append(32'd0, 16'h0100);
      lookup(32'd0);
   endtask

   // short ranges: 16-bit limits and the first-glyph append faults
   task automatic test_short_ranges();
      set_config(FMT_SHORT, 32'h0000_FFFF, 16'd256, 11'd3, 32'h0000_FFFF);
      clear_table();
      append(32'd0, 16'd0);
      append(32'h0000_00FF, 16'd255);
      append(32'h0000_FFFE, 16'd1);
      lookup(32'd0);
      lookup(32'h0000_00FE);
      lookup(32'h0000_00FF);
      lookup(32'h0000_FFFE);
      lookup(32'h0000_FFFF);
      set_config(FMT_SHORT, 32'h0000_FFFF, 16'd256, 11'd2, 32'h0000_FFFF);
      // first range not at glyph zero
      clear_table();
      append(32'd1, 16'd0);
      append(32'd5, 16'd0);
      lookup(32'd3);
      // first glyphs not rising
      clear_table();
      append(32'd0, 16'd0);
      append(32'd0, 16'd1);
      lookup(32'd3);
      // first glyph wider than 16 bits
      clear_table();
      append(32'd0, 16'd0);
      append(32'h0001_0000, 16'd1);
      lookup(32'd3);
      // sentinel wider than 16 bits
      set_config(FMT_SHORT, 32'h0001_0000, 16'd256, 11'd2, 32'h0001_0000);
      clear_table();
      append(32'd0, 16'd0);
      append(32'd5, 16'd1);
      lookup(32'd3);
   endtask

   // long ranges: 32-bit limits, sentinel and range count mismatches
   task automatic test_long_ranges();
      set_config(FMT_LONG, 32'hFFFF_FFFF, 16'hFFFF, 11'd2, 32'hFFFF_FFFF);
      clear_table();
      append(32'd0, 16'hFFFE);
      append(32'hFFFF_FFFE, 16'hABCD);
      lookup(32'd0);
      lookup(32'hFFFF_FFFD);
      lookup(32'hFFFF_FFFE);
      lookup(32'hFFFF_FFFF);
      set_config(FMT_LONG, 32'hFFFF_FFFF, 16'hFFFF, 11'd2, 32'hFFFF_FFFE);
      lookup(32'd7);
      set_config(FMT_LONG, 32'hFFFF_FFFF, 16'hFFFF, 11'd0, 32'hFFFF_FFFF);
      clear_table();
      lookup(32'd7);
      // dictionary at the count
      set_config(FMT_LONG, 32'd10, 16'hFFFF, 11'd1, 32'd10);
      append(32'd0, 16'hFFFF);
      lookup(32'd7);
   endtask

   // dictionary count and format rechecked at lookup time
   task automatic test_lookup_recheck();
      set_config(FMT_LONG, 32'd100, 16'd50, 11'd3, 32'd100);
      clear_table();
      append(32'd0, 16'd10);
      append(32'd20, 16'd40);
      append(32'd60, 16'd49);
      lookup(32'd30);
      set_config(FMT_LONG, 32'd100, 16'd41, 11'd3, 32'd100);
      lookup(32'd70);
      lookup(32'd30);
      lookup(32'd5);
      set_config(FMT_LONG, 32'd100, 16'd0, 11'd3, 32'd100);
      lookup(32'd5);
      wait_quiet();
      write_csr(CSR_SPARE, $urandom());
      csr_valid <= 1'b0;
      set_config(3'd5, 32'd100, 16'd50, 11'd3, 32'd100);
      lookup(32'd5);
      set_config(3'd7, 32'd100, 16'd50, 11'd3, 32'd100);
      lookup(32'd5);
      set_config(FMT_SHORT, 32'd100, 16'd50, 11'd3, 32'd100);
      lookup(32'd99);
   endtask

   // largest table: deepest search, then one append past the store
   task automatic test_full_store();
      bit [31:0] firsts [$];
      bit [31:0] glyphs;
      bit [31:0] first;
      int        k;
      glyphs = 32'(STORE_DEPTH * FULL_SPAN);
      set_config(FMT_LONG, glyphs, 16'hFFFF, 11'd1024, glyphs);
      clear_table();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         first = (i == 0) ? 32'd0 : 32'(i * FULL_SPAN + $urandom_range(0, FULL_SPAN - 1));
         firsts.push_back(first);
         append(first, 16'($urandom_range(0, 16'hFFFE)));
      end
      for (int i = 0; i < 24; i++) begin
         k = $urandom_range(1, STORE_DEPTH - 1);
         case ($urandom_range(0, 2))
            0: lookup($urandom_range(0, glyphs - 1));
            1: lookup(firsts[k]);
            default: lookup(firsts[k] - 32'd1);
         endcase
      end
      lookup(glyphs - 32'd1);
      lookup(glyphs);
      append(glyphs, 16'd0);
      lookup(32'd0);
      clear_table();
      lookup(32'd0);
   endtask

   // random tables: mostly well formed, some broken setups and stray commands
   task automatic test_random_tables();
      bit [31:0]       firsts [$];
      bit [2:0]        fmt;
      bit [31:0]       glyphs;
      bit [31:0]       sentinel;
      bit [31:0]       glyph;
      bit [15:0]       dicts;
      bit [15:0]       dict_top;
      bit [10:0]       ranges;
      longint unsigned span;
      int              n;
      int              m;
      int              k;
      int              sel;
      int              broken;
      int              goal;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         sel = $urandom_range(0, 9);
         if (sel < 3) fmt = FMT_BYTES;
         else if (sel < 6) fmt = FMT_SHORT;
         else if (sel < 9) fmt = FMT_LONG;
         else begin
            fmt = 3'($urandom_range(1, 5));
            if (fmt >= 3'd3) fmt = fmt + 3'd2;
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 128) : $urandom_range(1, 16);
         // table geometry
         if (fmt == FMT_BYTES)
            glyphs = 32'(n);
         else if (fmt == FMT_SHORT)
            glyphs = ($urandom_range(0, 4) == 0) ? 32'h0000_FFFF : $urandom_range(n, 16'hFFFF);
         else begin
            case ($urandom_range(0, 3))
               0: glyphs = $urandom_range(n, 1000);
               1: glyphs = 32'hFFFF_FFFF;
               default: glyphs = $urandom_range(n, 32'hFFFF_FFFF);
            endcase
         end
         if ($urandom_range(0, 19) == 0)
            dicts = 16'd0;
         else if (fmt == FMT_LONG || $urandom_range(0, 4) == 0)
            dicts = 16'($urandom_range(1, 16'hFFFF));
         else
            dicts = 16'($urandom_range(1, 256));
         dict_top = (dicts == 16'd0) ? 16'd0 : dicts - 16'd1;
         if ((fmt == FMT_BYTES || fmt == FMT_SHORT) && dict_top > 16'd255)
            dict_top = 16'd255;
         ranges = 11'(n);
         sentinel = glyphs;
         // occasionally a setup that does not match the table
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: ranges = ranges ^ 11'd1;
               1: sentinel = sentinel ^ (32'd1 << $urandom_range(0, 31));
               default: glyphs = glyphs + 32'd1;
            endcase
         end
         set_config(fmt, glyphs, dicts, ranges, sentinel);
         // ranges with strictly rising first glyphs below the glyph count
         firsts.delete();
         span = longint'(glyphs) / longint'(n);
         if (span == 0) span = 1;
         for (int i = 0; i < n; i++) begin
            if (fmt == FMT_BYTES) firsts.push_back($urandom());
            else if (i == 0) firsts.push_back(32'd0);
            else firsts.push_back(32'(i * span + $urandom_range(0, span - 1)));
         end
         clear_table();
         broken = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
         for (int i = 0; i < n; i++) begin
            if (i == broken) begin
               if ($urandom_range(0, 1) == 0)
                  append(firsts[i] ^ $urandom(), 16'($urandom()));
               else
                  append(firsts[i], 16'($urandom()));
            end else begin
               append(firsts[i], 16'($urandom_range(0, dict_top)));
            end
         end
         m = $urandom_range(4, 24);
         for (int i = 0; i < m; i++) begin
            k = $urandom_range(0, n - 1);
            sel = $urandom_range(0, 99);
            if (sel < 3) send_item(ACT_NOP, $urandom(), 16'($urandom()), $urandom());
            else if (sel < 5) append($urandom(), 16'($urandom()));
            else if (sel < 6) clear_table();
            else begin
               if (sel < 55) glyph = $urandom_range(0, glyphs - 1);
               else if (sel < 70) glyph = (fmt == FMT_BYTES) ? 32'(k) : firsts[k];
               else if (sel < 80) glyph = (fmt == FMT_BYTES) ? 32'(k) : firsts[k] - 32'd1;
               else if (sel < 90) glyph = glyphs + 32'($urandom_range(0, 2));
               else glyph = $urandom();
               lookup(glyph);
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_byte_table();
      test_short_ranges();
      test_long_ranges();
      test_lookup_recheck();
      test_full_store();
      test_random_tables();
      wait_quiet();
      $display("covered %0d commands (%0d lookups, %0d appends, %0d clears, %0d ignored)",
               items_sent + n_ignored, n_lookups, n_appends, n_clears, n_ignored);
      $display("%0d table setups, %0d answers checked, %0d mismatches, %0d answers missing",
               n_setups, answers_checked, mismatch_count, pending_answers.size());
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
